// ===== hdl/fpr_pkg.sv =====
// ----------------------------------------------------------------------------
// fpr_pkg: shared types and constants
// Opcodes, fixed field widths and the sequencer state type of the
// progression range-sum store.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int unsigned OPCODE_W = 1;
  localparam int unsigned INDEX_W  = 13;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned SUM_W    = 64;
  localparam int unsigned LANES    = 3;

  localparam logic [OPCODE_W-1:0] OP_ADD   = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_UM1,
    S_UM2,
    S_UM3,
    S_UM4,
    S_UM5,
    S_ADD_CHK,
    S_ADD_WR,
    S_SUM_CHK,
    S_SUM_ACC,
    S_QM1,
    S_QM2,
    S_OUT
  } fpr_state_t;

  // Signed divide by two, truncating toward zero.
  function automatic logic [SUM_W-1:0] halve(input logic [SUM_W-1:0] u);
    logic [SUM_W-1:0] t;
    begin
      t = u[SUM_W-1] ? (u + SUM_W'(1)) : u;
      halve = {t[SUM_W-1], t[SUM_W-1:1]};
    end
  endfunction

endpackage

// ===== hdl/fpr_if.sv =====
// ----------------------------------------------------------------------------
// fpr_if: request and result channels
// Valid/ready channels carrying one request in and one range sum out.
// ----------------------------------------------------------------------------
interface fpr_in_if;
  logic                              valid;
  logic                              ready;
  logic [fpr_pkg::OPCODE_W-1:0]      opcode;
  logic [fpr_pkg::INDEX_W-1:0]       left_index;
  logic [fpr_pkg::INDEX_W-1:0]       right_index;
  logic signed [fpr_pkg::VALUE_W-1:0] add_value;

  modport source (output valid, opcode, left_index, right_index, add_value, input ready);
  modport sink   (input valid, opcode, left_index, right_index, add_value, output ready);
endinterface

interface fpr_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [fpr_pkg::SUM_W-1:0] range_sum;

  modport source (output valid, range_sum, input ready);
  modport sink   (input valid, range_sum, output ready);
endinterface

// ===== hdl/fpr_tree_mem.sv =====
// ----------------------------------------------------------------------------
// fpr_tree_mem: coefficient tree storage
// One write port and one registered read port; each word holds the square,
// linear and constant coefficient of one tree node.
// ----------------------------------------------------------------------------
module fpr_tree_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned DW    = 192
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/fpr_mul64.sv =====
// ----------------------------------------------------------------------------
// fpr_mul64: multi-cycle wrapping multiplier
// Low 64 bits of a 64x64 product from three 32x32 partial products, one per
// cycle, each registered before it is accumulated.
// ----------------------------------------------------------------------------
module fpr_mul64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] result
);

  logic [63:0] a_r, b_r, prod_r, acc_r;
  logic [1:0]  cnt_r;
  logic        busy_r, done_r;
  logic [31:0] opa, opb;

  always_comb begin
    case (cnt_r)
      2'd0:    begin opa = a_r[31:0];  opb = b_r[31:0];  end
      2'd1:    begin opa = a_r[63:32]; opb = b_r[31:0];  end
      default: begin opa = a_r[31:0];  opb = b_r[63:32]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end else if (busy_r) begin
      prod_r <= opa * opb;
      if (cnt_r == 2'd1) begin
        acc_r <= prod_r;
      end else if (cnt_r != 2'd0) begin
        // Cross terms only reach the upper half.
        acc_r <= acc_r + {prod_r[31:0], 32'd0};
      end
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

// ===== hdl/fenwick_progression_range_sum.sv =====
// A query walks its tree nodes with a read per node (S_SUM_CHK, S_SUM_ACC) and an update
// with a read-modify-write per node (S_ADD_CHK, S_ADD_WR); the multiplier is used five
// times per update, four per query.
// One request is in work at a time; a finished sum waits in the output register.
// After reset a clearing pass zeroes every tree word before the first request is accepted.
// ----------------------------------------------------------------------------
// fenwick_progression_range_sum: progression add / range sum store
// Three Fenwick trees of quadratic prefix coefficients in one memory, walked
// by a sequencer with a shared multiplier.
// ----------------------------------------------------------------------------
module fenwick_progression_range_sum #(
  parameter int unsigned POSITIONS = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  fpr_in_if.sink          in_ch,
  fpr_out_if.source       out_ch
);

  localparam int unsigned AW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int unsigned NW = $clog2(POSITIONS + 1) + 1;
  localparam int unsigned SW = fpr_pkg::SUM_W;
  localparam int unsigned DW = SW * fpr_pkg::LANES;

  fpr_pkg::fpr_state_t state_r, state_nxt;

  logic [AW-1:0] clr_r;
  logic [NW-1:0] x_r, y_r, node_r;
  logic          side_r;
  logic          upd_r;
  logic [SW-1:0] val_r, m1_r, m2_r, lin_r, con_r, tail_r;
  logic [SW-1:0] d0_r, d1_r, d2_r;
  logic [SW-1:0] s0_r, s1_r, s2_r;
  logic [SW-1:0] py_r, res_r;
  logic          out_valid_r;
  logic [SW-1:0] out_data_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;

  logic          mul_start, mul_done;
  logic [SW-1:0] mul_a, mul_b, mul_res;

  logic          accept, in_valid_idx;
  logic [NW-1:0] lowbit, node_addr_full;
  logic          node_ok;
  logic [SW-1:0] l64, r64, p64, hval;
  logic          out_free;

  fpr_tree_mem #(.DEPTH(POSITIONS), .AW(AW), .DW(DW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fpr_mul64 u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  assign accept = in_ch.valid && in_ch.ready;
  assign in_valid_idx = (in_ch.left_index != '0) && (in_ch.right_index != '0)
                     && (32'(in_ch.left_index) <= 32'(POSITIONS))
                     && (32'(in_ch.right_index) <= 32'(POSITIONS));

  assign lowbit         = node_r & (~node_r + NW'(1));
  assign node_addr_full = node_r - NW'(1);
  assign node_ok        = (node_r != '0) && (node_r <= NW'(POSITIONS));
  assign l64            = SW'(x_r) - SW'(1);
  assign r64            = SW'(y_r) - SW'(x_r) + SW'(1);
  assign p64            = side_r ? (SW'(x_r) - SW'(1)) : SW'(y_r);
  assign hval           = fpr_pkg::halve(mul_res + s2_r);
  assign out_free       = !out_valid_r || out_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fpr_pkg::S_CLEAR:   if (clr_r == AW'(POSITIONS - 1)) state_nxt = fpr_pkg::S_IDLE;
      fpr_pkg::S_IDLE: begin
        if (accept) begin
          if (in_ch.opcode == fpr_pkg::OP_QUERY) begin
            state_nxt = in_valid_idx ? fpr_pkg::S_PREP : fpr_pkg::S_OUT;
          end else if (in_valid_idx && (in_ch.left_index <= in_ch.right_index)) begin
            state_nxt = fpr_pkg::S_PREP;
          end
        end
      end
      // An update leaves the prep cycle for the coefficient multiplies.
      fpr_pkg::S_PREP:    state_nxt = upd_r ? fpr_pkg::S_UM1 : fpr_pkg::S_SUM_CHK;
      fpr_pkg::S_UM1:     if (mul_done) state_nxt = fpr_pkg::S_UM2;
      fpr_pkg::S_UM2:     if (mul_done) state_nxt = fpr_pkg::S_UM3;
      fpr_pkg::S_UM3:     if (mul_done) state_nxt = fpr_pkg::S_UM4;
      fpr_pkg::S_UM4:     if (mul_done) state_nxt = fpr_pkg::S_UM5;
      fpr_pkg::S_UM5:     if (mul_done) state_nxt = fpr_pkg::S_ADD_CHK;
      fpr_pkg::S_ADD_CHK: begin
        if (node_ok)     state_nxt = fpr_pkg::S_ADD_WR;
        else if (side_r) state_nxt = fpr_pkg::S_IDLE;
      end
      fpr_pkg::S_ADD_WR:  state_nxt = fpr_pkg::S_ADD_CHK;
      fpr_pkg::S_SUM_CHK: state_nxt = (node_r != '0) ? fpr_pkg::S_SUM_ACC : fpr_pkg::S_QM1;
      fpr_pkg::S_SUM_ACC: state_nxt = fpr_pkg::S_SUM_CHK;
      fpr_pkg::S_QM1:     if (mul_done) state_nxt = fpr_pkg::S_QM2;
      fpr_pkg::S_QM2: begin
        if (mul_done) state_nxt = side_r ? fpr_pkg::S_OUT : fpr_pkg::S_SUM_CHK;
      end
      fpr_pkg::S_OUT:     if (out_free) state_nxt = fpr_pkg::S_IDLE;
      default:            state_nxt = fpr_pkg::S_IDLE;
    endcase
  end

  // Outputs: memory port, multiplier operands, handshake.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(node_addr_full);
    mem_wdata = {mem_rdata[3*SW-1:2*SW] + d2_r,
                 mem_rdata[2*SW-1:SW]   + d1_r,
                 mem_rdata[SW-1:0]      + d0_r};
    mem_raddr = AW'(node_addr_full);
    mul_start = 1'b0;
    mul_a     = l64;
    mul_b     = l64 - SW'(1);
    in_ch.ready = 1'b0;
    unique case (state_r)
      fpr_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      fpr_pkg::S_IDLE: in_ch.ready = 1'b1;
      fpr_pkg::S_PREP: mul_start = upd_r;
      fpr_pkg::S_UM1: begin
        mul_start = mul_done;
        mul_a     = r64;
        mul_b     = r64 + SW'(1);
      end
      fpr_pkg::S_UM2: begin
        mul_start = mul_done;
        mul_a     = val_r;
        mul_b     = SW'(1) - (l64 << 1);
      end
      fpr_pkg::S_UM3: begin
        mul_start = mul_done;
        mul_a     = val_r;
        mul_b     = m1_r;
      end
      fpr_pkg::S_UM4: begin
        mul_start = mul_done;
        mul_a     = val_r;
        mul_b     = m2_r;
      end
      fpr_pkg::S_ADD_WR: mem_we = 1'b1;
      fpr_pkg::S_SUM_CHK: begin
        mul_start = (node_r == '0);
        mul_a     = s0_r;
        mul_b     = p64;
      end
      fpr_pkg::S_QM1: begin
        mul_start = mul_done;
        mul_a     = mul_res + s1_r;
        mul_b     = p64;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpr_pkg::S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == fpr_pkg::S_CLEAR) clr_r <= clr_r + AW'(1);
      if (state_r == fpr_pkg::S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      fpr_pkg::S_IDLE: begin
        x_r    <= NW'(in_ch.left_index);
        y_r    <= NW'(in_ch.right_index);
        val_r  <= {{(SW-fpr_pkg::VALUE_W){in_ch.add_value[fpr_pkg::VALUE_W-1]}},
                   in_ch.add_value};
        upd_r  <= (in_ch.opcode == fpr_pkg::OP_ADD);
        side_r <= 1'b0;
        res_r  <= '0;
      end
      fpr_pkg::S_PREP: begin
        node_r <= y_r;
        s0_r   <= '0;
        s1_r   <= '0;
        s2_r   <= '0;
      end
      fpr_pkg::S_UM1: if (mul_done) m1_r  <= mul_res;
      fpr_pkg::S_UM2: if (mul_done) m2_r  <= mul_res;
      fpr_pkg::S_UM3: if (mul_done) lin_r <= mul_res;
      fpr_pkg::S_UM4: if (mul_done) con_r <= mul_res;
      fpr_pkg::S_UM5: begin
        if (mul_done) begin
          tail_r <= mul_res;
          node_r <= x_r;
          d0_r   <= val_r;
          d1_r   <= lin_r;
          d2_r   <= con_r;
        end
      end
      fpr_pkg::S_ADD_CHK: begin
        if (!node_ok && !side_r) begin
          // Second leg cancels the progression past the right end.
          side_r <= 1'b1;
          node_r <= y_r + NW'(1);
          d0_r   <= SW'(0) - val_r;
          d1_r   <= SW'(0) - lin_r;
          d2_r   <= tail_r - con_r;
        end
      end
      fpr_pkg::S_ADD_WR:  node_r <= node_r + lowbit;
      fpr_pkg::S_SUM_ACC: begin
        s0_r   <= s0_r + mem_rdata[SW-1:0];
        s1_r   <= s1_r + mem_rdata[2*SW-1:SW];
        s2_r   <= s2_r + mem_rdata[3*SW-1:2*SW];
        node_r <= node_r - lowbit;
      end
      fpr_pkg::S_QM2: begin
        if (mul_done) begin
          if (!side_r) begin
            py_r   <= hval;
            side_r <= 1'b1;
            node_r <= x_r - NW'(1);
            s0_r   <= '0;
            s1_r   <= '0;
            s2_r   <= '0;
          end else begin
            res_r <= py_r - hval;
          end
        end
      end
      fpr_pkg::S_OUT: if (out_free) out_data_r <= res_r;
      default: ;
    endcase
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.range_sum = out_data_r;

endmodule

// ===== test/fpr_scoreboard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fpr_scoreboard: range-sum predictor and checker
// Tracks the positions of the store as three coefficient trees and checks
// each range sum that the block returns against the predicted value.
// ----------------------------------------------------------------------------
class fpr_scoreboard;
  localparam int unsigned NPOS = 4096;

  logic [63:0] sq_tree  [NPOS];
  logic [63:0] lin_tree [NPOS];
  logic [63:0] con_tree [NPOS];
  logic [63:0] pending_sums[$];
  int          mismatches;

  function new();
    for (int i = 0; i < NPOS; i++) begin
      sq_tree[i]  = '0;
      lin_tree[i] = '0;
      con_tree[i] = '0;
    end
    mismatches = 0;
  endfunction

  function void tree_bump(int which, int unsigned node, logic [63:0] v);
    while (node >= 1 && node <= NPOS) begin
      case (which)
        0: sq_tree[node-1]  += v;
        1: lin_tree[node-1] += v;
        default: con_tree[node-1] += v;
      endcase
      node += node & (~node + 1);
    end
  endfunction

  function logic [63:0] tree_total(int which, int unsigned node);
    logic [63:0] s;
    s = '0;
    if (node > NPOS) node = NPOS;
    while (node != 0) begin
      case (which)
        0: s += sq_tree[node-1];
        1: s += lin_tree[node-1];
        default: s += con_tree[node-1];
      endcase
      node -= node & (~node + 1);
    end
    return s;
  endfunction

  function logic [63:0] prefix_sum(int unsigned p);
    logic [63:0] pp, u;
    pp = 64'(p);
    u = tree_total(0, p) * pp * pp + tree_total(1, p) * pp + tree_total(2, p);
    if (u[63]) return -((-u) >> 1);
    return u >> 1;
  endfunction

  // Notes one accepted request: updates the trees or queues the expected sum.
  function void note_request(logic [0:0] op, int unsigned x, int unsigned y,
                             logic signed [31:0] add_value);
    logic [63:0] val, l, r, lin, con, tail, want;
    bit ok;
    ok = x >= 1 && y >= 1 && x <= NPOS && y <= NPOS;
    val = 64'(add_value);
    if (op == fpr_pkg::OP_QUERY) begin
      want = ok ? prefix_sum(y) - prefix_sum(x - 1) : 64'd0;
      pending_sums = {pending_sums, want};
    end else if (ok && x <= y) begin
      l = 64'(x - 1);
      r = 64'(y - x + 1);
      lin = val * (64'd1 - 64'd2 * l);
      con = val * (l * l - l);
      tail = val * (r * r + r);
      tree_bump(0, x, val);
      tree_bump(0, y + 1, -val);
      tree_bump(1, x, lin);
      tree_bump(1, y + 1, -lin);
      tree_bump(2, x, con);
      tree_bump(2, y + 1, tail - con);
    end
  endfunction

  function void check_sum(logic [63:0] got);
    logic [63:0] want;
    if (pending_sums.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected range sum %h", got);
      return;
    end
    want = pending_sums.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("range_sum mismatch: expected %h, got %h", want, got);
    end
  endfunction
endclass

// ===== test/fenwick_progression_range_sum_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fenwick_progression_range_sum_test: self-checking bench
// Drives directed and random progression updates and range queries with
// random idling on both channels and checks every returned sum.
// ----------------------------------------------------------------------------
module fenwick_progression_range_sum_test;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   quiet_phase = 1'b0;

  fpr_in_if  in_ch();
  fpr_out_if out_ch();
  fpr_scoreboard sums = new();

  fenwick_progression_range_sum dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #5 clk = ~clk;

  // Result side: random stalls, sums checked at the rising edge.
  always @(negedge clk) out_ch.ready <= quiet_phase || ($urandom_range(99) >= 19);
  always @(posedge clk)
    if (rst_n && out_ch.valid && out_ch.ready) sums.check_sum(out_ch.range_sum);

  task automatic send_request(logic [0:0] op, int unsigned x, int unsigned y,
                              logic signed [31:0] v);
    while (!quiet_phase && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.left_index <= 13'(x);
    in_ch.right_index <= 13'(y);
    in_ch.add_value <= v;
    do @(posedge clk); while (!in_ch.ready);
    // The block sees only the low 13 bits of each index.
    sums.note_request(op, x & 32'h1FFF, y & 32'h1FFF, v);
    @(negedge clk);
  endtask

  // Mostly legal ranges, with some out-of-range and reversed indexes.
  function automatic int unsigned pick_index();
    int k;
    k = $urandom_range(99);
    if (k < 4) return $urandom_range(8191);
    if (k < 8) return 0;
    if (k < 12) return 4096 - $urandom_range(3);
    if (k < 50) return 1 + $urandom_range(31);
    return 1 + $urandom_range(4095);
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sums.pending_sums.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  initial begin
    int unsigned a, b;
    logic [0:0] op;
    logic signed [31:0] v;
    in_ch.valid = 1'b0;
    in_ch.opcode = fpr_pkg::OP_ADD;
    in_ch.left_index = '0;
    in_ch.right_index = '0;
    in_ch.add_value = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    send_request(fpr_pkg::OP_QUERY, 1, 4096, 0);
    send_request(fpr_pkg::OP_ADD, 1, 4096, 32'sh7fffffff);
    send_request(fpr_pkg::OP_QUERY, 1, 4096, 0);
    send_request(fpr_pkg::OP_ADD, 4096, 4096, 32'sh80000000);
    send_request(fpr_pkg::OP_ADD, 1, 1, -1);
    send_request(fpr_pkg::OP_ADD, 5, 17, 3);
    send_request(fpr_pkg::OP_ADD, 10, 3, 99);
    send_request(fpr_pkg::OP_ADD, 0, 5, 7);
    send_request(fpr_pkg::OP_ADD, 4097, 8191, 7);
    send_request(fpr_pkg::OP_QUERY, 1, 1, 0);
    send_request(fpr_pkg::OP_QUERY, 4096, 4096, 0);
    send_request(fpr_pkg::OP_QUERY, 5, 17, 32'shffffffff);
    send_request(fpr_pkg::OP_QUERY, 17, 5, 0);
    send_request(fpr_pkg::OP_QUERY, 0, 10, 0);
    send_request(fpr_pkg::OP_QUERY, 10, 0, 0);
    send_request(fpr_pkg::OP_QUERY, 8191, 8191, 0);
    send_request(fpr_pkg::OP_QUERY, 4097, 4096, 0);
    send_request(fpr_pkg::OP_ADD, 2, 4095, 32'sh55555555);
    send_request(fpr_pkg::OP_QUERY, 1, 4096, 0);

    // Hold off until every sum is back before the random part.
    drain();

    for (int n = 0; n < 1350; n++) begin
      quiet_phase = (n >= 400 && n < 550);
      a = pick_index();
      b = ($urandom_range(9) == 0) ? pick_index() : a + $urandom_range(40);
      if (b > 4096 && a <= 4096 && $urandom_range(3) != 0) b = 4096;
      op = 1'($urandom_range(1));
      v = $urandom_range(3) == 0 ? 32'($urandom_range(15)) - 8 : 32'($urandom);
      send_request(op, a, b, v);
    end
    quiet_phase = 1'b0;
    drain();
    if (sums.mismatches == 0 && sums.pending_sums.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/fpr_pkg.sv
hdl/fpr_if.sv
hdl/fpr_tree_mem.sv
hdl/fpr_mul64.sv
hdl/fenwick_progression_range_sum.sv
test/fpr_scoreboard.sv
test/fenwick_progression_range_sum_test.sv
